FILE: sv/bbsb_pkg.sv
// Package: types, codes and sizes for the backtracking byte stream buffer.
package bbsb_pkg;

  localparam int unsigned BufferDepth   = 256;
  localparam int unsigned MarkCountBits = 16;
  localparam int unsigned CursorW       = $clog2(BufferDepth);
  localparam int unsigned FillW         = CursorW + 1;
  localparam logic [7:0]  NewlineByte   = 8'h0A;

  typedef enum logic [2:0] {
    ACT_CURRENT   = 3'd0,
    ACT_NEXT      = 3'd1,
    ACT_PREVIOUS  = 3'd2,
    ACT_MARK      = 3'd3,
    ACT_LOAD_MARK = 3'd4,
    ACT_DROP_MARK = 3'd5,
    ACT_RESET     = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_AT_START  = 3'd1,
    STAT_NO_MARK   = 3'd2,
    STAT_DROP_NONE = 3'd3,
    STAT_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    LOP_NONE,
    LOP_INC,
    LOP_DEC
  } line_op_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_LOOKUP
  } fsm_e;

  typedef struct packed {
    action_e     action;
    logic [7:0]  source_byte;
    logic [7:0]  source_byte_after;
    logic [7:0]  mark_position;
    logic [31:0] mark_line;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  current_byte;
    logic        byte_valid;
    logic [1:0]  bytes_taken;
    logic [7:0]  mark_position_out;
    logic [31:0] mark_line_out;
    logic [31:0] line_count;
    status_e     status;
  } out_item_t;

  typedef struct packed {
    logic        want;
    logic        in_range;
    logic [1:0]  taken;
    logic [7:0]  mpos;
    logic [31:0] mline;
    status_e     status;
    line_op_e    line_op;
  } pend_res_t;

endpackage

FILE: sv/bbsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bbsb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/backtracking_byte_stream_buffer_core.sv
// Top level: backtracking byte stream buffer with its byte store in a RAM.
// An accepted action is registered into the lookup state; its result beat is then registered onto the output.
// A new action is taken only once the previous one has left the lookup state, which waits for the registered read
// of the byte store at the updated cursor (a second store write, when needed, overlaps that read).
// Reset: asynchronous, active low; clears cursor, fill, marks and flags, line counter to 1.
// Byte store contents are not cleared; only filled entries are ever reported.
module backtracking_byte_stream_buffer_core
  import bbsb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam logic [FillW-1:0]         FillFull  = FillW'(BufferDepth);
  localparam logic [CursorW-1:0]       CursorMax = CursorW'(BufferDepth - 1);
  localparam logic [MarkCountBits-1:0] MarksMax  = '1;

  fsm_e state_q, state_d;

  logic [FillW-1:0]         fill_q, fill_d;
  logic [CursorW-1:0]       cursor_q, cursor_d;
  logic [MarkCountBits-1:0] marks_q, marks_d;
  logic                     saving_q, saving_d;
  logic                     primed_q, primed_d;
  logic [31:0]              line_q, line_d;

  pend_res_t res_q, res_d;
  logic      fwd_v_q, fwd_v_d;
  logic [7:0] fwd_data_q, fwd_data_d;
  logic       pend_v_q, pend_v_d;
  logic [CursorW-1:0] pend_addr_q, pend_addr_d;
  logic [7:0] pend_data_q, pend_data_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic accept;
  logic wa_v, wb_v, wa_keep;
  logic [CursorW-1:0] wa_addr, wb_addr;
  logic [7:0] wa_data, wb_data;
  logic [FillW-1:0] fill_t;
  logic [7:0] next_c;
  logic push_ok;

  logic               ram_we;
  logic [CursorW-1:0] ram_waddr;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;
  logic [7:0]         rd_byte;
  logic               rd_valid;
  logic               is_nl;

  assign in_stall_o  = (state_q != FSM_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign push_ok = fill_q < FillFull;
  assign next_c  = primed_q ? in_data_i.source_byte : in_data_i.source_byte_after;

  always_comb begin
    fill_d   = fill_q;
    cursor_d = cursor_q;
    marks_d  = marks_q;
    saving_d = saving_q;
    primed_d = primed_q;
    fill_t   = fill_q;
    wa_v     = 1'b0;
    wa_addr  = fill_q[CursorW-1:0];
    wa_data  = in_data_i.source_byte;
    wb_v     = 1'b0;
    wb_addr  = '0;
    wb_data  = next_c;
    res_d    = '{want: 1'b0, in_range: 1'b0, taken: 2'd0, mpos: 8'd0, mline: 32'd0,
                 status: STAT_OK, line_op: LOP_NONE};

    unique case (in_data_i.action)
      ACT_CURRENT: begin
        if (!primed_q) begin
          primed_d    = 1'b1;
          res_d.taken = 2'd1;
          if (push_ok) begin
            wa_v   = 1'b1;
            fill_d = fill_q + 1'b1;
          end else begin
            res_d.status = STAT_FULL;
          end
        end
        res_d.want = 1'b1;
      end
      ACT_NEXT: begin
        if (!primed_q) begin
          primed_d    = 1'b1;
          res_d.taken = 2'd1;
          if (push_ok) begin
            wa_v   = 1'b1;
            fill_t = fill_q + 1'b1;
          end else begin
            res_d.status = STAT_FULL;
          end
        end
        fill_d = fill_t;
        if (saving_q) begin
          if ({1'b0, cursor_q} + 1'b1 < fill_t) begin
            cursor_d = cursor_q + 1'b1;
          end else begin
            res_d.taken = res_d.taken + 2'd1;
            if (marks_q != '0) begin
              if (fill_t < FillFull) begin
                wb_v    = 1'b1;
                wb_addr = fill_t[CursorW-1:0];
                fill_d  = fill_t + 1'b1;
                if (cursor_q != CursorMax) begin
                  cursor_d = cursor_q + 1'b1;
                end
              end else begin
                res_d.status = STAT_FULL;
              end
            end else begin
              wb_v     = 1'b1;
              fill_d   = FillW'(1);
              cursor_d = '0;
              saving_d = 1'b0;
            end
          end
        end else begin
          res_d.taken = res_d.taken + 2'd1;
          wb_v        = 1'b1;
          if (fill_t == '0) begin
            fill_d = FillW'(1);
          end
        end
        res_d.want    = 1'b1;
        res_d.line_op = LOP_INC;
      end
      ACT_PREVIOUS: begin
        if (marks_q == '0) begin
          res_d.status = STAT_NO_MARK;
        end else if (cursor_q == '0) begin
          res_d.status = STAT_AT_START;
        end else begin
          cursor_d = cursor_q - 1'b1;
          if (!primed_q) begin
            primed_d    = 1'b1;
            res_d.taken = 2'd1;
            if (push_ok) begin
              wa_v   = 1'b1;
              fill_d = fill_q + 1'b1;
            end else begin
              res_d.status = STAT_FULL;
            end
          end
          res_d.want    = 1'b1;
          res_d.line_op = LOP_DEC;
        end
      end
      ACT_MARK: begin
        saving_d = 1'b1;
        if (marks_q != MarksMax) begin
          marks_d = marks_q + 1'b1;
        end
        res_d.mpos  = 8'(cursor_q);
        res_d.mline = line_q;
      end
      ACT_LOAD_MARK: begin
        if (FillW'(in_data_i.mark_position) < FillFull) begin
          cursor_d = CursorW'(in_data_i.mark_position);
        end else begin
          cursor_d = CursorMax;
        end
      end
      ACT_DROP_MARK: begin
        if (marks_q != '0) begin
          marks_d = marks_q - 1'b1;
        end else begin
          res_d.status = STAT_DROP_NONE;
        end
      end
      ACT_RESET: begin
        fill_d   = '0;
        cursor_d = '0;
        marks_d  = '0;
        saving_d = 1'b0;
        primed_d = 1'b0;
      end
      default: begin
      end
    endcase

    res_d.in_range = {1'b0, cursor_d} < fill_d;

    wa_keep = wa_v && !(wb_v && (wb_addr == wa_addr));

    if (wb_v && (wb_addr == cursor_d)) begin
      fwd_v_d    = 1'b1;
      fwd_data_d = wb_data;
    end else begin
      fwd_v_d    = wa_keep && (wa_addr == cursor_d);
      fwd_data_d = wa_data;
    end

    pend_v_d    = wa_keep && wb_v;
    pend_addr_d = wb_addr;
    pend_data_d = wb_data;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr_q;
    ram_wdata = pend_data_q;
    if (accept) begin
      ram_we    = wa_keep || wb_v;
      ram_waddr = wa_keep ? wa_addr : wb_addr;
      ram_wdata = wa_keep ? wa_data : wb_data;
    end else if (state_q == FSM_LOOKUP && pend_v_q) begin
      ram_we = 1'b1;
    end
  end

  bbsb_ram #(
    .Width(8),
    .Depth(BufferDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(cursor_d),
    .rdata_o(ram_rdata)
  );

  assign rd_byte  = fwd_v_q ? fwd_data_q : ram_rdata;
  assign rd_valid = res_q.want && res_q.in_range;
  assign is_nl    = rd_valid && (rd_byte == NewlineByte);

  always_comb begin
    state_d     = state_q;
    line_d      = line_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_LOOKUP;
          if (in_data_i.action == ACT_LOAD_MARK) begin
            line_d = in_data_i.mark_line;
          end else if (in_data_i.action == ACT_RESET) begin
            line_d = 32'd1;
          end
        end
      end
      FSM_LOOKUP: begin
        state_d = FSM_IDLE;
        if (is_nl && res_q.line_op == LOP_INC && line_q != '1) begin
          line_d = line_q + 32'd1;
        end else if (is_nl && res_q.line_op == LOP_DEC && line_q != '0) begin
          line_d = line_q - 32'd1;
        end
        out_valid_d             = 1'b1;
        out_d.current_byte      = rd_valid ? rd_byte : 8'd0;
        out_d.byte_valid        = rd_valid;
        out_d.bytes_taken       = res_q.taken;
        out_d.mark_position_out = res_q.mpos;
        out_d.mark_line_out     = res_q.mline;
        out_d.line_count        = line_d;
        out_d.status            = res_q.status;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      fill_q      <= '0;
      cursor_q    <= '0;
      marks_q     <= '0;
      saving_q    <= 1'b0;
      primed_q    <= 1'b0;
      line_q      <= 32'd1;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      line_q      <= line_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        fill_q   <= fill_d;
        cursor_q <= cursor_d;
        marks_q  <= marks_d;
        saving_q <= saving_d;
        primed_q <= primed_d;
        pend_v_q <= pend_v_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      res_q       <= res_d;
      fwd_v_q     <= fwd_v_d;
      fwd_data_q  <= fwd_data_d;
      pend_addr_q <= pend_addr_d;
      pend_data_q <= pend_data_d;
    end
  end

endmodule
